// ===== rtl/core/keyed_record_table_sorted_query_core_defines.svh =====
// ----------------------------------------------------------------------------
// keyed record table core: assertion macros
// shared helpers for the concurrent checks of the core
// ----------------------------------------------------------------------------
`ifndef KEYED_RECORD_TABLE_SORTED_QUERY_CORE_DEFINES_SVH
`define KEYED_RECORD_TABLE_SORTED_QUERY_CORE_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define KRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define KRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg
// types, codes and widths shared by the keyed record table core
// ----------------------------------------------------------------------------
package krt_pkg;

  // default table depth
  localparam int unsigned KRT_DEPTH = 64;

  // fixed field widths
  localparam int unsigned KRT_KEY_W  = 16;
  localparam int unsigned KRT_MEM_W  = 8;
  localparam int unsigned KRT_CAT_W  = 2;
  localparam int unsigned KRT_ROOM_W = 12;
  localparam int unsigned KRT_CNT_W  = 7;
  localparam int unsigned KRT_REC_W  = KRT_KEY_W + KRT_MEM_W + KRT_CAT_W + KRT_ROOM_W;

  // action codes
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_LIST   = 2'd2,
    ACT_COUNT  = 2'd3
  } act_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_KEY,
    S_SCAN_CNT,
    S_SCAN_BEST,
    S_EMIT,
    S_RESP
  } state_e;

  // stored record, key in the top bits
  typedef struct packed {
    logic [KRT_KEY_W-1:0]  key;
    logic [KRT_MEM_W-1:0]  members;
    logic [KRT_CAT_W-1:0]  cat;
    logic [KRT_ROOM_W-1:0] room;
  } rec_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    scan_init;
    logic    scan;
    logic    clr_marks;
    logic    latch_total;
    logic    write_ins;
    logic    write_upd;
    logic    status_we;
    status_e status;
    logic    emit_rec;
    logic    emit_resp;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    act_e                 act;
    logic                 full;
    logic                 scan_done;
    logic                 found;
    logic                 none;
    logic                 last_rec;
    logic                 out_free;
    logic [KRT_CNT_W-1:0] fill;
  } sts_t;

endpackage

// ===== rtl/core/keyed_record_table_sorted_query_core.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table_sorted_query_core
// keyed record table with insert, update, sorted category list and count
// ----------------------------------------------------------------------------
// channel   dir  tdata fields (low bit up)                     tuser   tlast
// s_axis    in   key, members, category, room                  action  -
// m_axis    out  key, members, category, room, stored count    status  last word
//
// insert and update scan all stored records for the key; an insert when the
// table is full skips the scan and answers full.
// a list takes one counting scan, then one max-finding scan per matching
// record, each followed by the emit of that record; count needs no scan.
// the scans are set by the single read port of the record ram.
// reset clears fill level, list position and scan state; the store needs no clear.
// a stalled output word holds the controller before the next word only.
// ----------------------------------------------------------------------------
`include "keyed_record_table_sorted_query_core_defines.svh"

module keyed_record_table_sorted_query_core import krt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = KRT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // key[15:0], members[23:16], category[25:24], room[37:26], zero pad
  input  logic [39:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // key[15:0], members[23:16], category[25:24], room[37:26],
  // stored count[44:38], zero pad
  output logic [47:0] m_axis_tdata,
  // status[2:0]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  cmd_t   cmd;
  sts_t   sts;
  state_e state;

  // sequencer
  krt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .state_o   (state)
  );

  // table and output datapath
  krt_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser),
    .out_last_o (m_axis_tlast)
  );

  // checks
  `KRT_ASSERT_NOW(a_fill_bound, 1'b1, sts.fill <= KRT_CNT_W'(TABLE_DEPTH), "fill level above depth")
  `KRT_ASSERT_NEXT(a_fill_step, 1'b1, (sts.fill == $past(sts.fill)) || (sts.fill == KRT_CNT_W'($past(sts.fill) + 1'b1)), "fill level jumped")
  `KRT_ASSERT_NOW(a_mid_list_ok, m_axis_tvalid && !m_axis_tlast, m_axis_tuser == ST_OK, "non-final word without ok status")
  `KRT_ASSERT_NOW(a_ready_idle, s_axis_tready, state == S_IDLE && !cmd.emit_rec, "input taken while busy")

endmodule

// ===== rtl/core/krt_ram.sv =====
// ----------------------------------------------------------------------------
// krt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module krt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/krt_datapath.sv =====
// ----------------------------------------------------------------------------
// krt_datapath
// record store, scan compare logic, list position and output word register
// ----------------------------------------------------------------------------
module krt_datapath import krt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = KRT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [39:0] in_data_i,
  input  logic [1:0]  in_user_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [47:0] out_data_o,
  output logic [2:0]  out_user_o,
  output logic        out_last_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // held input word
  act_e                  act_q;
  logic [KRT_KEY_W-1:0]  key_q;
  logic [KRT_MEM_W-1:0]  mem_q;
  logic [KRT_CAT_W-1:0]  cat_q;
  logic [KRT_ROOM_W-1:0] room_q;

  logic [CW-1:0] fill_q;
  logic [CW-1:0] cnt_q;
  logic          rvalid_q;
  logic [AW-1:0] ridx_q;
  logic          issue;
  rec_t          rdata;

  logic          found_q;
  logic [AW-1:0] found_idx_q;
  rec_t          found_rec_q;
  logic [CW-1:0] match_cnt_q;
  logic [CW-1:0] total_q;
  logic [CW-1:0] emit_cnt_q;
  logic          best_v_q;
  logic [AW-1:0] best_idx_q;
  rec_t          best_rec_q;
  logic                 prev_v_q;
  logic [KRT_MEM_W-1:0] prev_mem_q;
  logic [AW-1:0]        prev_idx_q;
  status_e       status_q;

  logic hit_key, hit_cat, eligible, better, is_last;

  logic          we;
  logic [AW-1:0] waddr;
  rec_t          wdata;

  logic          out_v_q;
  logic [47:0]   out_data_q;
  logic [2:0]    out_user_q;
  logic          out_last_q;
  logic          out_free;

  // capture the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= act_e'(in_user_i);
      key_q  <= in_data_i[15:0];
      mem_q  <= in_data_i[23:16];
      cat_q  <= in_data_i[25:24];
      room_q <= in_data_i[37:26];
    end
  end

  // scan address and read pipeline
  assign issue = cmd_i.scan && (cnt_q < fill_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rvalid_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      rvalid_q <= issue;
      if (cmd_i.scan_init) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.write_ins) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= cnt_q[AW-1:0];
  end

  // record store
  always_comb begin
    wdata = '0;
    if (cmd_i.write_ins) begin
      wdata = '{key: key_q, members: mem_q, cat: cat_q, room: room_q};
    end else begin
      wdata     = found_rec_q;
      wdata.cat = cat_q;
    end
  end

  assign we    = cmd_i.write_ins | cmd_i.write_upd;
  assign waddr = cmd_i.write_ins ? fill_q[AW-1:0] : found_idx_q;

  krt_ram #(
    .WIDTH(KRT_REC_W),
    .DEPTH(TABLE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(cnt_q[AW-1:0]),
    .rdata_o(rdata)
  );

  // compares on the entry just read
  // an entry is still to come if it sorts after the last emitted one:
  // fewer members, or equal members further down the table
  assign hit_key  = rvalid_q && (rdata.key == key_q);
  assign hit_cat  = rvalid_q && (rdata.cat == cat_q);
  assign eligible = !prev_v_q || (rdata.members < prev_mem_q) ||
                    ((rdata.members == prev_mem_q) && (ridx_q > prev_idx_q));
  assign better   = hit_cat && eligible &&
                    (!best_v_q || (rdata.members > best_rec_q.members));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      best_v_q    <= 1'b0;
      match_cnt_q <= '0;
      total_q     <= '0;
      emit_cnt_q  <= '0;
      prev_v_q    <= 1'b0;
      prev_mem_q  <= '0;
      prev_idx_q  <= '0;
      status_q    <= ST_OK;
    end else begin
      if (cmd_i.scan_init) begin
        found_q     <= 1'b0;
        best_v_q    <= 1'b0;
        match_cnt_q <= '0;
      end else begin
        if (hit_key) found_q <= 1'b1;
        if (better) best_v_q <= 1'b1;
        if (hit_cat) match_cnt_q <= match_cnt_q + 1'b1;
      end
      if (cmd_i.latch_total) total_q <= match_cnt_q;
      if (cmd_i.load) begin
        emit_cnt_q <= '0;
      end else if (cmd_i.emit_rec) begin
        emit_cnt_q <= emit_cnt_q + 1'b1;
      end
      // position of the last emitted record in the sorted order
      if (cmd_i.clr_marks) begin
        prev_v_q <= 1'b0;
      end else if (cmd_i.emit_rec) begin
        prev_v_q   <= 1'b1;
        prev_mem_q <= best_rec_q.members;
        prev_idx_q <= best_idx_q;
      end
      if (cmd_i.status_we) status_q <= cmd_i.status;
    end
  end

  // payload of the scan winners
  always_ff @(posedge clk_i) begin
    if (hit_key && !cmd_i.scan_init) begin
      found_idx_q <= ridx_q;
      found_rec_q <= rdata;
    end
    if (better && !cmd_i.scan_init) begin
      best_idx_q <= ridx_q;
      best_rec_q <= rdata;
    end
  end

  assign is_last = (CW'(emit_cnt_q + 1'b1) == total_q);

  // output word register
  assign out_free = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.emit_rec || cmd_i.emit_resp) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_rec) begin
      out_data_q <= {3'b000, KRT_CNT_W'(fill_q), best_rec_q.room, best_rec_q.cat,
                     best_rec_q.members, best_rec_q.key};
      out_user_q <= ST_OK;
      out_last_q <= is_last;
    end else if (cmd_i.emit_resp) begin
      out_data_q <= {3'b000, KRT_CNT_W'(fill_q), 38'd0};
      out_user_q <= status_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;
  assign out_last_o  = out_last_q;

  // status to the controller
  assign sts_o.act       = act_q;
  assign sts_o.full      = (fill_q >= CW'(TABLE_DEPTH));
  assign sts_o.scan_done = (cnt_q >= fill_q) && !rvalid_q;
  assign sts_o.found     = found_q;
  assign sts_o.none      = (match_cnt_q == '0);
  assign sts_o.last_rec  = is_last;
  assign sts_o.out_free  = out_free;
  assign sts_o.fill      = KRT_CNT_W'(fill_q);

endmodule

// ===== rtl/core/krt_ctrl.sv =====
// ----------------------------------------------------------------------------
// krt_ctrl
// sequencer for insert, update, sorted list and count actions
// ----------------------------------------------------------------------------
module krt_ctrl import krt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  sts_t   sts_i,
  output cmd_t   cmd_o,
  output state_e state_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.status = ST_OK;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load      = 1'b1;
          cmd_o.scan_init = 1'b1;
          state_d         = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.act)
          ACT_INSERT: begin
            if (sts_i.full) begin
              cmd_o.status_we = 1'b1;
              cmd_o.status    = ST_FULL;
              state_d         = S_RESP;
            end else begin
              state_d = S_SCAN_KEY;
            end
          end
          ACT_UPDATE: state_d = S_SCAN_KEY;
          ACT_LIST: begin
            cmd_o.clr_marks = 1'b1;
            state_d         = S_SCAN_CNT;
          end
          ACT_COUNT: begin
            cmd_o.status_we = 1'b1;
            cmd_o.status    = ST_OK;
            state_d         = S_RESP;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SCAN_KEY: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.status_we = 1'b1;
          state_d         = S_RESP;
          if (sts_i.act == ACT_INSERT) begin
            if (sts_i.found) begin
              cmd_o.status = ST_DUPLICATE;
            end else begin
              cmd_o.write_ins = 1'b1;
              cmd_o.status    = ST_OK;
            end
          end else begin
            if (sts_i.found) begin
              cmd_o.write_upd = 1'b1;
              cmd_o.status    = ST_OK;
            end else begin
              cmd_o.status = ST_NOT_FOUND;
            end
          end
        end
      end
      S_SCAN_CNT: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.latch_total = 1'b1;
          if (sts_i.none) begin
            cmd_o.status_we = 1'b1;
            cmd_o.status    = ST_EMPTY;
            state_d         = S_RESP;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN_BEST;
          end
        end
      end
      S_SCAN_BEST: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_rec = 1'b1;
          if (sts_i.last_rec) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN_BEST;
          end
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.emit_resp = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign state_o = state_q;

endmodule

// ===== tb/tb_keyed_record_table_sorted_query_core.sv =====
// ----------------------------------------------------------------------------
// tb_keyed_record_table_sorted_query_core
// stream-level check of the record table against a behavioural table model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keyed_record_table_sorted_query_core;
  import krt_pkg::*;

  localparam int unsigned DEPTH = KRT_DEPTH;
  localparam int unsigned STALL_LIMIT = 200000;

  typedef struct packed {
    act_e        act;
    logic [15:0] key;
    logic [7:0]  members;
    logic [1:0]  cat;
    logic [11:0] room;
  } cmd_word_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] key;
    logic [7:0]  members;
    logic [1:0]  cat;
    logic [11:0] room;
    logic [6:0]  stored;
    logic        last;
  } resp_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  keyed_record_table_sorted_query_core DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  // model state
  rec_t        tbl_rec [DEPTH];
  int unsigned tbl_fill;

  cmd_word_t  pending_cmds[$];
  resp_word_t expected_resps[$];
  logic [15:0] used_keys[$];
  int  mismatches;
  bit  stim_done;
  bit  hold_sender;
  int  long_stall;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic resp_word_t plain_resp(status_e st);
    resp_word_t r;
    r = '0;
    r.status = st;
    r.stored = tbl_fill[6:0];
    r.last = 1'b1;
    return r;
  endfunction

  // table model: appends the words one command causes
  task automatic predict_table(cmd_word_t c);
    int hit;
    int best;
    bit taken [DEPTH];
    int found_cnt;
    resp_word_t r;
    hit = -1;
    for (int i = 0; i < tbl_fill; i++) if (tbl_rec[i].key == c.key && hit < 0) hit = i;
    case (c.act)
      ACT_INSERT: begin
        if (tbl_fill >= DEPTH) expected_resps.push_back(plain_resp(ST_FULL));
        else if (hit >= 0) expected_resps.push_back(plain_resp(ST_DUPLICATE));
        else begin
          tbl_rec[tbl_fill] = '{c.key, c.members, c.cat, c.room};
          tbl_fill++;
          expected_resps.push_back(plain_resp(ST_OK));
        end
      end
      ACT_UPDATE: begin
        if (hit >= 0) begin
          tbl_rec[hit].cat = c.cat;
          expected_resps.push_back(plain_resp(ST_OK));
        end else expected_resps.push_back(plain_resp(ST_NOT_FOUND));
      end
      ACT_LIST: begin
        found_cnt = 0;
        foreach (taken[i]) taken[i] = 1'b0;
        forever begin
          best = -1;
          for (int i = 0; i < tbl_fill; i++)
            if (!taken[i] && tbl_rec[i].cat == c.cat &&
                (best < 0 || tbl_rec[i].members > tbl_rec[best].members)) best = i;
          if (best < 0) break;
          taken[best] = 1'b1;
          r = plain_resp(ST_OK);
          r.key = tbl_rec[best].key;
          r.members = tbl_rec[best].members;
          r.cat = tbl_rec[best].cat;
          r.room = tbl_rec[best].room;
          r.last = 1'b0;
          expected_resps.push_back(r);
          found_cnt++;
        end
        if (found_cnt == 0) expected_resps.push_back(plain_resp(ST_EMPTY));
        else expected_resps[$].last = 1'b1;
      end
      default: expected_resps.push_back(plain_resp(ST_OK));
    endcase
  endtask

  function automatic cmd_word_t mk(act_e a, logic [15:0] k, logic [7:0] m,
                                   logic [1:0] ct, logic [11:0] rm);
    cmd_word_t c;
    c.act = a; c.key = k; c.members = m; c.cat = ct; c.room = rm;
    return c;
  endfunction

  // random key: reuse a known key one time in three so update and duplicate paths are hit
  function automatic logic [15:0] pick_key();
    logic [15:0] k;
    if (used_keys.size() > 0 && $urandom_range(0, 2) == 0)
      k = used_keys[$urandom_range(0, used_keys.size() - 1)];
    else begin
      k = 16'($urandom);
      used_keys.push_back(k);
    end
    return k;
  endfunction

  function automatic cmd_word_t rand_cmd(int ins_weight);
    int sel;
    act_e a;
    sel = $urandom_range(0, 9);
    if (sel < ins_weight) a = ACT_INSERT;
    else if (sel < 7) a = ACT_UPDATE;
    else if (sel < 9) a = ACT_LIST;
    else a = ACT_COUNT;
    // few distinct member counts so ties are frequent
    return mk(a, pick_key(), $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom),
              2'($urandom), 12'($urandom));
  endfunction

  // stimulus
  initial begin
    stim_done = 1'b0;
    hold_sender = 1'b0;
    long_stall = 0;
    // directed part
    pending_cmds.push_back(mk(ACT_COUNT, 16'h0, 8'h0, 2'd0, 12'h0));
    pending_cmds.push_back(mk(ACT_LIST, 16'h0, 8'h0, 2'd3, 12'h0));
    pending_cmds.push_back(mk(ACT_UPDATE, 16'hFFFF, 8'h0, 2'd1, 12'h0));
    pending_cmds.push_back(mk(ACT_INSERT, 16'h0000, 8'h00, 2'd0, 12'h000));
    pending_cmds.push_back(mk(ACT_INSERT, 16'hFFFF, 8'hFF, 2'd3, 12'hFFF));
    pending_cmds.push_back(mk(ACT_INSERT, 16'hFFFF, 8'h10, 2'd0, 12'h123));
    pending_cmds.push_back(mk(ACT_INSERT, 16'h1234, 8'h80, 2'd0, 12'hABC));
    pending_cmds.push_back(mk(ACT_INSERT, 16'h5555, 8'h80, 2'd0, 12'h555));
    pending_cmds.push_back(mk(ACT_INSERT, 16'hAAAA, 8'hFF, 2'd0, 12'hAAA));
    pending_cmds.push_back(mk(ACT_LIST, 16'h0, 8'h0, 2'd0, 12'h0));
    pending_cmds.push_back(mk(ACT_UPDATE, 16'h1234, 8'h0, 2'd3, 12'h0));
    pending_cmds.push_back(mk(ACT_UPDATE, 16'h4321, 8'h0, 2'd2, 12'h0));
    pending_cmds.push_back(mk(ACT_LIST, 16'h0, 8'h0, 2'd3, 12'h0));
    pending_cmds.push_back(mk(ACT_LIST, 16'h0, 8'h0, 2'd2, 12'h0));
    pending_cmds.push_back(mk(ACT_COUNT, 16'hFFFF, 8'hFF, 2'd3, 12'hFFF));
    // random fill towards a full table, then full-table inserts
    for (int i = 0; i < 180; i++) pending_cmds.push_back(rand_cmd(6));
    for (int i = 0; i < 70; i++)
      pending_cmds.push_back(mk(ACT_INSERT, 16'($urandom), 8'($urandom), 2'($urandom),
                                12'($urandom)));
    for (int i = 0; i < 8; i++) pending_cmds.push_back(mk(ACT_LIST, 16'h0, 8'h0, 2'(i), 12'h0));
    for (int i = 0; i < 150; i++) pending_cmds.push_back(rand_cmd(3));
    // long receiver hold-off while the sender keeps offering
    wait (pending_cmds.size() < 300);
    long_stall = 3000;
    wait (long_stall == 0);
    // sender pause until the pipe is empty
    wait (pending_cmds.size() < 100);
    hold_sender = 1'b1;
    wait (expected_resps.size() == 0);
    hold_sender = 1'b0;
    wait (pending_cmds.size() == 0);
    stim_done = 1'b1;
  end

  // driver
  int send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      send_gap <= 0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
      // hold the word
    end else if (send_gap > 0) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_cmds.size() > 0 && !hold_sender) begin
      cmd_word_t c;
      c = pending_cmds.pop_front();
      predict_table(c);
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= {2'b0, c.room, c.cat, c.members, c.key};
      s_axis_tuser <= c.act;
      send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // monitor and receiver stall
  int recv_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap <= 0;
      mismatches <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        resp_word_t got;
        resp_word_t exp_w;
        got.status = status_e'(m_axis_tuser);
        got.key = m_axis_tdata[15:0];
        got.members = m_axis_tdata[23:16];
        got.cat = m_axis_tdata[25:24];
        got.room = m_axis_tdata[37:26];
        got.stored = m_axis_tdata[44:38];
        got.last = m_axis_tlast;
        if (expected_resps.size() == 0) begin
          if (mismatches < 10) $display("unexpected word %h", got);
          mismatches <= mismatches + 1;
        end else begin
          exp_w = expected_resps.pop_front();
          if (got !== exp_w) begin
            if (mismatches < 10)
              $display("mismatch: st %0d/%0d key %h/%h mem %h/%h cat %0d/%0d room %h/%h cnt %0d/%0d last %b/%b",
                       exp_w.status, got.status, exp_w.key, got.key, exp_w.members,
                       got.members, exp_w.cat, got.cat, exp_w.room, got.room,
                       exp_w.stored, got.stored, exp_w.last, got.last);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (long_stall > 0) begin
        m_axis_tready <= 1'b0;
        long_stall <= long_stall - 1;
      end else if (m_axis_tvalid && m_axis_tready || !m_axis_tvalid && recv_gap == 0) begin
        recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end else if (recv_gap > 0) begin
        m_axis_tready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // reset, watchdog and end of run
  int idle_cycles;
  initial begin
    rst_ni = 1'b0;
    idle_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
      if (stim_done && expected_resps.size() == 0 && !s_axis_tvalid) begin
        repeat (300) @(posedge clk_i);
        if (mismatches == 0 && expected_resps.size() == 0) begin
          $display("simulation ok");
        end else begin
          $display("simulation failed");
        end
        $finish;
      end
    end
  end

endmodule
